// File: src/esc_pkg.sv
// ----------------------------------------------------------------------------
// esc_pkg
// Shared types, codes and helpers of the environmental sensor compensation.
// ----------------------------------------------------------------------------
package esc_pkg;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = 1;
	localparam int QCNT_W      = 2;
	localparam int DIV_STEPS   = 64;
	localparam int DCNT_W      = 7;

	localparam logic [19:0] SKIP20  = 20'h80000;
	localparam logic [15:0] SKIP16  = 16'h8000;
	localparam int          HUM_MAX = 419430400;

	typedef logic signed [63:0] s64_t;

	typedef enum logic [2:0] {
		CFG_TEMP    = 3'd0,
		CFG_PRESS_A = 3'd1,
		CFG_PRESS_B = 3'd2,
		CFG_PRESS_C = 3'd3,
		CFG_HUM     = 3'd4
	} cfg_idx_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_SKIP = 2'd1,
		ST_ZERO = 2'd2
	} status_t;

	typedef struct packed {
		logic [19:0] ap;
		logic [19:0] at;
		logic [15:0] ah;
		logic        skip;
	} item_t;

	typedef struct packed {
		logic  valid;
		item_t item;
	} qhead_t;

	typedef struct packed {
		logic        valid;
		logic [2:0]  index;
		logic [63:0] data;
	} cfg_wr_t;

	function automatic s64_t sx16(input logic [15:0] x);
		return {{48{x[15]}}, x};
	endfunction

	function automatic s64_t sx12(input logic [11:0] x);
		return {{52{x[11]}}, x};
	endfunction

	function automatic s64_t sx8(input logic [7:0] x);
		return {{56{x[7]}}, x};
	endfunction

	// wrap to 32 bits and sign extend back
	function automatic s64_t w32(input s64_t x);
		return {{32{x[31]}}, x[31:0]};
	endfunction

endpackage

// File: src/esc_mul.sv
// ----------------------------------------------------------------------------
// esc_mul
// 64 x 64 multiplier keeping the low 64 bits, built from three 32 x 32
// partial products on one multiplier, one after another.
// ----------------------------------------------------------------------------
module esc_mul
	import esc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] a,
	input  logic [63:0] b,
	output logic        done,
	output logic [63:0] p
);

	logic        busy_q;
	logic [1:0]  cnt_q;
	logic        done_q;
	logic [63:0] a_q, b_q, prod_q, acc_q;
	logic [31:0] ma, mb;

	always_comb begin
		unique case (cnt_q)
			2'd0: begin ma = a_q[31:0];  mb = b_q[31:0];  end
			2'd1: begin ma = a_q[31:0];  mb = b_q[63:32]; end
			default: begin ma = a_q[63:32]; mb = b_q[31:0]; end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= 2'd0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 2'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 2'd1;
				if (cnt_q == 2'd3) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			b_q <= b;
		end else if (busy_q) begin
			prod_q <= {32'd0, ma} * {32'd0, mb};
			if (cnt_q == 2'd1)
				acc_q <= prod_q;
			else if (cnt_q != 2'd0)
				acc_q[63:32] <= acc_q[63:32] + prod_q[31:0];
		end
	end

	assign done = done_q;
	assign p    = acc_q;

endmodule

// File: src/esc_div.sv
// ----------------------------------------------------------------------------
// esc_div
// Signed 64-bit divider truncating toward zero, restoring, one quotient bit
// per cycle on the magnitudes.
// ----------------------------------------------------------------------------
module esc_div
	import esc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  s64_t        n,
	input  s64_t        d,
	output logic        done,
	output logic [63:0] q
);

	logic              busy_q;
	logic [DCNT_W-1:0] cnt_q;
	logic              done_q;
	logic              neg_q;
	logic [63:0]       rem_q, qr_q, ud_q;
	logic [64:0]       rem_sh, rem_sub;

	assign rem_sh  = {rem_q, qr_q[63]};
	assign rem_sub = rem_sh - {1'b0, ud_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DCNT_W'(DIV_STEPS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DCNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			qr_q  <= n[63] ? 64'd0 - n : n;
			ud_q  <= d[63] ? 64'd0 - d : d;
			neg_q <= n[63] ^ d[63];
			rem_q <= '0;
		end else if (busy_q) begin
			if (!rem_sub[64]) begin
				rem_q <= rem_sub[63:0];
				qr_q  <= {qr_q[62:0], 1'b1};
			end else begin
				rem_q <= rem_sh[63:0];
				qr_q  <= {qr_q[62:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign q    = neg_q ? 64'd0 - qr_q : qr_q;

endmodule

// File: src/esc_front.sv
// ----------------------------------------------------------------------------
// esc_front
// Accepts raw readings, flags skipped measurements and queues them.
// ----------------------------------------------------------------------------
module esc_front
	import esc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [19:0] raw_pressure,
	input  logic [19:0] raw_temperature,
	input  logic [15:0] raw_humidity,
	output qhead_t      head,
	input  logic        pop
);

	item_t             mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q, rd_q;
	logic [QCNT_W-1:0] count_q;
	logic              push;
	item_t             it;

	always_comb begin
		it.ap   = raw_pressure;
		it.at   = raw_temperature;
		it.ah   = raw_humidity;
		it.skip = (raw_pressure == SKIP20) || (raw_temperature == SKIP20) ||
		          (raw_humidity == SKIP16);
	end

	assign in_stall   = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign push       = in_valid && !in_stall;
	assign head.valid = (count_q != '0);
	assign head.item  = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + 1'b1;
			if (pop)
				rd_q <= rd_q + 1'b1;
			count_q <= count_q + QCNT_W'(push) - QCNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= it;
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QUEUE_DEPTH)) else $error("queue overfilled");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != '0) else $error("pop from empty queue");
	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> count_q == $past(count_q) + 1'b1)
		else $error("push lost");

endmodule

// File: src/esc_back.sv
// ----------------------------------------------------------------------------
// esc_back
// Sequencer running the compensation on a shared multiplier and divider,
// holding the calibration registers and the output register.
// ----------------------------------------------------------------------------
module esc_back
	import esc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_wr_t            cfg,
	input  qhead_t             head,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] temperature_centi,
	output logic [31:0]        pressure_q24_8,
	output logic [16:0]        humidity_q22_10,
	output logic [1:0]         result_status
);

	typedef enum logic [5:0] {
		S_IDLE, S_T1, S_T2, S_T3, S_TC,
		S_P5, S_P6, S_P7, S_P8, S_P9, S_P10, S_PCHK, S_P11, S_DIV,
		S_P12, S_P13, S_P14, S_PF, S_PG,
		S_H15, S_H16, S_H17, S_H18, S_H19, S_H20, S_H21, S_H22, S_HC,
		S_OUT
	} state_t;

	state_t state_q, next_step;
	logic   issued_q;

	logic [47:0] tcal_q;
	logic [63:0] pa_q, pb_q, hcal_q;
	logic [15:0] pc_q;

	logic [19:0] ap_q, at_q;
	logic [15:0] ah_q;
	s64_t        va_q, x_q, tf_q, tc_q, v1_q, sq_q, v2_q, w_q, num_q, p_q, m_q;
	s64_t        left_q, g_q, k_q, vv_q;
	logic [31:0] pq_q;
	logic [16:0] hum_q;
	status_t     status_q;
	logic        out_valid_q;
	logic signed [31:0] o_temp_q;
	logic [31:0] o_press_q;
	logic [16:0] o_hum_q;
	status_t     o_status_q;

	s64_t t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9, h1, h2, h3, h4, h5, h6;
	s64_t ap_s, at_s, ah_s, hv, mp, lo, dq, pr, s15, vcl;
	s64_t mul_a, mul_b;
	logic is_mul, is_div, mul_start, div_start, mul_done, div_done, step_done;
	logic out_free;
	logic [63:0] mul_p, div_q;

	always_comb begin
		t1 = {48'd0, tcal_q[15:0]};
		t2 = sx16(tcal_q[31:16]);
		t3 = sx16(tcal_q[47:32]);
		p1 = {48'd0, pa_q[15:0]};
		p2 = sx16(pa_q[31:16]);
		p3 = sx16(pa_q[47:32]);
		p4 = sx16(pa_q[63:48]);
		p5 = sx16(pb_q[15:0]);
		p6 = sx16(pb_q[31:16]);
		p7 = sx16(pb_q[47:32]);
		p8 = sx16(pb_q[63:48]);
		p9 = sx16(pc_q);
		h1 = {56'd0, hcal_q[7:0]};
		h2 = sx16(hcal_q[23:8]);
		h3 = {56'd0, hcal_q[31:24]};
		h4 = sx12(hcal_q[43:32]);
		h5 = sx12(hcal_q[55:44]);
		h6 = sx8(hcal_q[63:56]);
		ap_s = {44'd0, ap_q};
		at_s = {44'd0, at_q};
		ah_s = {48'd0, ah_q};
		hv   = w32(tf_q - 64'sd76800);
		mp   = mul_p;
		lo   = w32(mp);
		dq   = div_q;
		pr   = (p_q >>> 8) + (p7 <<< 4);
		s15  = vv_q >>> 15;
		if (vv_q < 0)
			vcl = '0;
		else if (vv_q > 64'(HUM_MAX))
			vcl = 64'(HUM_MAX);
		else
			vcl = vv_q;
	end

	// operands and successor state of each multiply and divide step
	always_comb begin
		is_mul    = 1'b1;
		is_div    = 1'b0;
		mul_a     = '0;
		mul_b     = '0;
		next_step = S_IDLE;
		unique case (state_q)
			S_T1: begin
				mul_a = w32((at_s >>> 3) - (t1 <<< 1)); mul_b = t2; next_step = S_T2;
			end
			S_T2: begin
				mul_a = (at_s >>> 4) - t1; mul_b = (at_s >>> 4) - t1; next_step = S_T3;
			end
			S_T3:  begin mul_a = x_q;  mul_b = t3; next_step = S_TC;  end
			S_P5:  begin mul_a = v1_q; mul_b = v1_q; next_step = S_P6; end
			S_P6:  begin mul_a = sq_q; mul_b = p6; next_step = S_P7;  end
			S_P7:  begin mul_a = v1_q; mul_b = p5; next_step = S_P8;  end
			S_P8:  begin mul_a = sq_q; mul_b = p3; next_step = S_P9;  end
			S_P9:  begin mul_a = v1_q; mul_b = p2; next_step = S_P10; end
			S_P10: begin
				mul_a = v1_q + (64'sd1 <<< 47); mul_b = p1; next_step = S_PCHK;
			end
			S_P11: begin
				mul_a = ((64'sd1048576 - ap_s) <<< 31) - v2_q; mul_b = 64'sd3125;
				next_step = S_DIV;
			end
			S_DIV: begin is_mul = 1'b0; is_div = 1'b1; next_step = S_P12; end
			S_P12: begin mul_a = p9;   mul_b = p_q >>> 13; next_step = S_P13; end
			S_P13: begin mul_a = m_q;  mul_b = p_q >>> 13; next_step = S_P14; end
			S_P14: begin mul_a = p8;   mul_b = p_q; next_step = S_PF; end
			S_H15: begin mul_a = h5;   mul_b = hv;  next_step = S_H16; end
			S_H16: begin mul_a = hv;   mul_b = h6;  next_step = S_H17; end
			S_H17: begin mul_a = hv;   mul_b = h3;  next_step = S_H18; end
			S_H18: begin mul_a = g_q;  mul_b = k_q; next_step = S_H19; end
			S_H19: begin
				mul_a = w32(g_q + 64'sd2097152); mul_b = h2; next_step = S_H20;
			end
			S_H20: begin mul_a = left_q; mul_b = k_q; next_step = S_H21; end
			S_H21: begin mul_a = s15;  mul_b = s15; next_step = S_H22; end
			S_H22: begin mul_a = g_q;  mul_b = h1;  next_step = S_HC;  end
			default: is_mul = 1'b0;
		endcase
	end

	assign mul_start = is_mul && !issued_q;
	assign div_start = is_div && !issued_q;
	assign step_done = (is_mul && mul_done) || (is_div && div_done);
	assign pop       = (state_q == S_IDLE) && head.valid;
	assign out_free  = !out_valid_q || !out_stall;

	esc_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.p      (mul_p)
	);

	esc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.n      (num_q),
		.d      (v1_q),
		.done   (div_done),
		.q      (div_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tcal_q <= '0;
			pa_q   <= '0;
			pb_q   <= '0;
			pc_q   <= '0;
			hcal_q <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_TEMP:    tcal_q <= cfg.data[47:0];
				CFG_PRESS_A: pa_q   <= cfg.data;
				CFG_PRESS_B: pb_q   <= cfg.data;
				CFG_PRESS_C: pc_q   <= cfg.data[15:0];
				CFG_HUM:     hcal_q <= cfg.data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			issued_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_OUT && out_free)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (head.valid)
						state_q <= head.item.skip ? S_OUT : S_T1;
				end
				S_TC:   state_q <= S_P5;
				S_PCHK: state_q <= (v1_q == '0) ? S_OUT : S_P11;
				S_PF:   state_q <= S_PG;
				S_PG:   state_q <= (pr[31:0] == '0) ? S_OUT : S_H15;
				S_HC:   state_q <= S_OUT;
				S_OUT: begin
					if (out_free)
						state_q <= S_IDLE;
				end
				default: begin
					if (!issued_q)
						issued_q <= 1'b1;
					if (step_done) begin
						issued_q <= 1'b0;
						state_q  <= next_step;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && head.valid) begin
			ap_q     <= head.item.ap;
			at_q     <= head.item.at;
			ah_q     <= head.item.ah;
			status_q <= head.item.skip ? ST_SKIP : ST_OK;
		end
		if (step_done) begin
			unique case (state_q)
				S_T1:  va_q  <= lo >>> 11;
				S_T2:  x_q   <= lo >>> 12;
				S_T3:  tf_q  <= w32(va_q + (lo >>> 14));
				S_P5:  sq_q  <= mp;
				S_P6:  v2_q  <= mp + (p4 <<< 35);
				S_P7:  v2_q  <= v2_q + (mp <<< 17);
				S_P8:  w_q   <= mp >>> 8;
				S_P9:  v1_q  <= w_q + (mp <<< 12);
				S_P10: v1_q  <= mp >>> 33;
				S_P11: num_q <= mp;
				S_DIV: p_q   <= dq;
				S_P12: m_q   <= mp;
				S_P13: v1_q  <= mp >>> 25;
				S_P14: v2_q  <= mp >>> 19;
				S_H15: left_q <= w32((ah_s <<< 14) - (h4 <<< 20) - lo + 64'sd16384) >>> 15;
				S_H16: g_q   <= lo >>> 10;
				S_H17: k_q   <= w32((lo >>> 11) + 64'sd32768);
				S_H18: g_q   <= lo >>> 10;
				S_H19: k_q   <= w32(lo + 64'sd8192) >>> 14;
				S_H20: vv_q  <= lo;
				S_H21: g_q   <= lo >>> 7;
				S_H22: vv_q  <= w32(vv_q - (lo >>> 4));
				default: ;
			endcase
		end
		unique case (state_q)
			S_TC: begin
				tc_q <= w32((tf_q <<< 2) + tf_q + 64'sd128) >>> 8;
				v1_q <= tf_q - 64'sd128000;
			end
			S_PCHK: if (v1_q == '0) status_q <= ST_ZERO;
			S_PF:   p_q <= p_q + v1_q + v2_q;
			S_PG: begin
				pq_q <= pr[31:0];
				if (pr[31:0] == '0)
					status_q <= ST_ZERO;
			end
			S_HC:   hum_q <= vcl[28:12];
			S_OUT: begin
				if (out_free) begin
					o_temp_q   <= (status_q == ST_SKIP) ? '0 : tc_q[31:0];
					o_press_q  <= (status_q == ST_OK) ? pq_q : '0;
					o_hum_q    <= (status_q == ST_OK) ? hum_q : '0;
					o_status_q <= status_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid         = out_valid_q;
	assign temperature_centi = o_temp_q;
	assign pressure_q24_8    = o_press_q;
	assign humidity_q22_10   = o_hum_q;
	assign result_status     = o_status_q;

	a_mul_issued: assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> issued_q) else $error("multiplier result without request");
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> v1_q != '0) else $error("division by zero started");
	a_issued_step: assert property (@(posedge clk) disable iff (!arst_n)
		issued_q |-> (is_mul || is_div)) else $error("request outside a unit step");

endmodule

// File: src/env_sensor_compensation.sv
// A skipped measurement goes from the queue straight to the output state; a full
// item runs 21 multiplies on the shared multiplier, one radix-2 restoring divide,
// 5 steps without a unit, the pop in S_IDLE and the output state.
// The back end takes a new item only once the last one is out; while it works or
// the output is stalled, two readings queue up front.
// reset: arst_n clears the calibration registers to zero, the queue and the sequencer.
// ----------------------------------------------------------------------------
// env_sensor_compensation
// Integer temperature, pressure and humidity compensation of raw readings.
// ----------------------------------------------------------------------------
module env_sensor_compensation
	import esc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [19:0]        raw_pressure,
	input  logic [19:0]        raw_temperature,
	input  logic [15:0]        raw_humidity,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] temperature_centi,
	output logic [31:0]        pressure_q24_8,
	output logic [16:0]        humidity_q22_10,
	output logic [1:0]         result_status,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [63:0]        cfg_data
);

	qhead_t  head;
	logic    pop;
	cfg_wr_t cfg;

	assign cfg_ready = 1'b1;
	assign cfg.valid = cfg_valid && cfg_ready;
	assign cfg.index = cfg_index;
	assign cfg.data  = cfg_data;

	esc_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.raw_pressure    (raw_pressure),
		.raw_temperature (raw_temperature),
		.raw_humidity    (raw_humidity),
		.head            (head),
		.pop             (pop)
	);

	esc_back u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg               (cfg),
		.head              (head),
		.pop               (pop),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.temperature_centi (temperature_centi),
		.pressure_q24_8    (pressure_q24_8),
		.humidity_q22_10   (humidity_q22_10),
		.result_status     (result_status)
	);

endmodule

// File: tb/esc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esc_checker
// Watches the reading, result and calibration channels of the compensation
// block, predicts every result from the calibration in force and compares.
// ----------------------------------------------------------------------------
module esc_checker
	import esc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic [19:0]        raw_pressure,
	input  logic [19:0]        raw_temperature,
	input  logic [15:0]        raw_humidity,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic signed [31:0] temperature_centi,
	input  logic [31:0]        pressure_q24_8,
	input  logic [16:0]        humidity_q22_10,
	input  logic [1:0]         result_status,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [63:0]        cfg_data,
	output int                 pending,
	output int                 fail_count,
	output int                 status_seen [3]
);

	typedef logic signed [31:0] s32_t;

	typedef struct {
		s32_t        temp;
		logic [31:0] press;
		logic [16:0] hum;
		status_t     status;
	} reading_t;

	logic [47:0] temp_cal;
	logic [63:0] press_cal_a;
	logic [63:0] press_cal_b;
	logic [15:0] press_cal_c;
	logic [63:0] hum_cal;

	reading_t expected_readings [$];

	// signed division truncating toward zero, most negative / -1 wraps
	function automatic s64_t div_trunc(input s64_t n, input s64_t d);
		logic [63:0] un;
		logic [63:0] ud;
		logic [63:0] q;
		un = n < 0 ? -n : n;
		ud = d < 0 ? -d : d;
		q  = un / ud;
		return ((n < 0) != (d < 0)) ? s64_t'(-q) : s64_t'(q);
	endfunction

	function automatic reading_t compensate(input logic [19:0] ap, input logic [19:0] at,
			input logic [15:0] ah);
		reading_t r;
		s32_t t1, t2, t3, adt, va, vb, d, m, tf;
		s64_t p1, p2, p3, p4, p5, p6, p7, p8, p9, v1, v2, p;
		s32_t h1, h2, h3, h4, h5, h6, v, left, inner, right, x;
		r.temp   = 0;
		r.press  = 0;
		r.hum    = 0;
		r.status = ST_OK;
		if (ap == SKIP20 || at == SKIP20 || ah == SKIP16) begin
			r.status = ST_SKIP;
			return r;
		end
		t1  = {16'd0, temp_cal[15:0]};
		t2  = $signed(temp_cal[31:16]);
		t3  = $signed(temp_cal[47:32]);
		adt = {12'd0, at};
		m   = (adt >>> 3) - t1 * 2;
		m   = m * t2;
		va  = m >>> 11;
		d   = (adt >>> 4) - t1;
		m   = d * d;
		m   = m >>> 12;
		m   = m * t3;
		vb  = m >>> 14;
		tf  = va + vb;
		m   = tf * 5 + 128;
		r.temp = m >>> 8;

		p1 = {48'd0, press_cal_a[15:0]};
		p2 = $signed(press_cal_a[31:16]);
		p3 = $signed(press_cal_a[47:32]);
		p4 = $signed(press_cal_a[63:48]);
		p5 = $signed(press_cal_b[15:0]);
		p6 = $signed(press_cal_b[31:16]);
		p7 = $signed(press_cal_b[47:32]);
		p8 = $signed(press_cal_b[63:48]);
		p9 = $signed(press_cal_c);
		v1 = tf;
		v1 = v1 - 64'sd128000;
		v2 = v1 * v1 * p6;
		v2 = v2 + ((v1 * p5) <<< 17);
		v2 = v2 + (p4 <<< 35);
		v1 = ((v1 * v1 * p3) >>> 8) + ((v1 * p2) <<< 12);
		v1 = (((64'sd1 <<< 47) + v1) * p1) >>> 33;
		if (v1 == 0) begin
			r.status = ST_ZERO;
			return r;
		end
		p  = 64'sd1048576 - s64_t'({44'd0, ap});
		p  = ((p <<< 31) - v2) * 64'sd3125;
		p  = div_trunc(p, v1);
		v1 = (p9 * (p >>> 13) * (p >>> 13)) >>> 25;
		v2 = (p8 * p) >>> 19;
		p  = ((p + v1 + v2) >>> 8) + (p7 <<< 4);
		if (p[31:0] == 0) begin
			r.status = ST_ZERO;
			return r;
		end
		r.press = p[31:0];

		h1 = {24'd0, hum_cal[7:0]};
		h2 = $signed(hum_cal[23:8]);
		h3 = {24'd0, hum_cal[31:24]};
		h4 = $signed(hum_cal[43:32]);
		h5 = $signed(hum_cal[55:44]);
		h6 = $signed(hum_cal[63:56]);
		v  = tf - 76800;
		left  = s32_t'({16'd0, ah}) <<< 14;
		left  = left - (h4 <<< 20) - h5 * v + 16384;
		left  = left >>> 15;
		x     = v * h3;
		x     = (x >>> 11) + 32768;
		inner = v * h6;
		inner = inner >>> 10;
		inner = inner * x;
		inner = inner >>> 10;
		right = (inner + 2097152) * h2 + 8192;
		right = right >>> 14;
		v = left * right;
		x = v >>> 15;
		x = x * x;
		x = x >>> 7;
		x = x * h1;
		x = x >>> 4;
		v = v - x;
		if (v < 0)
			v = 0;
		if (v > HUM_MAX)
			v = HUM_MAX;
		r.hum = v[28:12];
		return r;
	endfunction

	assign pending = expected_readings.size();

	always @(posedge clk or negedge arst_n) begin
		reading_t e;
		if (!arst_n) begin
			temp_cal    <= '0;
			press_cal_a <= '0;
			press_cal_b <= '0;
			press_cal_c <= '0;
			hum_cal     <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_idx_t'(cfg_index))
					CFG_TEMP:    temp_cal    <= cfg_data[47:0];
					CFG_PRESS_A: press_cal_a <= cfg_data;
					CFG_PRESS_B: press_cal_b <= cfg_data;
					CFG_PRESS_C: press_cal_c <= cfg_data[15:0];
					CFG_HUM:     hum_cal     <= cfg_data;
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				expected_readings.push_back(compensate(raw_pressure, raw_temperature,
					raw_humidity));
			if (out_valid && !out_stall) begin
				if (expected_readings.size() == 0) begin
					fail_count++;
					$display("%0t: result transaction with nothing expected", $time);
				end else begin
					e = expected_readings.pop_front();
					status_seen[e.status]++;
					if (temperature_centi !== e.temp) begin
						fail_count++;
						$display("%0t: temperature_centi expected %0d actual %0d", $time,
							e.temp, temperature_centi);
					end
					if (pressure_q24_8 !== e.press) begin
						fail_count++;
						$display("%0t: pressure_q24_8 expected %0d actual %0d", $time,
							e.press, pressure_q24_8);
					end
					if (humidity_q22_10 !== e.hum) begin
						fail_count++;
						$display("%0t: humidity_q22_10 expected %0d actual %0d", $time,
							e.hum, humidity_q22_10);
					end
					if (result_status !== e.status) begin
						fail_count++;
						$display("%0t: result_status expected %0d actual %0d", $time,
							e.status, result_status);
					end
				end
			end
		end
	end

	initial begin
		fail_count = 0;
		status_seen = '{0, 0, 0};
	end

endmodule

// File: tb/tb_env_sensor_compensation.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_env_sensor_compensation
// Drives raw readings and calibration sets into the compensation block with
// random gaps and stalls on both sides; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_env_sensor_compensation;
	import esc_pkg::*;

	localparam logic [47:0] TYP_TEMP    = 48'hFC18_6743_6B70;
	localparam logic [63:0] TYP_PRESS_A = 64'h0B27_0BD0_D643_8E7D;
	localparam logic [63:0] TYP_PRESS_B = 64'hC6F8_3C8C_FFF9_008C;
	localparam logic [15:0] TYP_PRESS_C = 16'h1770;
	localparam logic [63:0] TYP_HUM     = 64'h1E03_2139_0001_6A4B;
	localparam int          N_PHASES    = 6;
	localparam int          PHASE_ITEMS = 205;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [19:0]        raw_pressure;
	logic [19:0]        raw_temperature;
	logic [15:0]        raw_humidity;
	logic               out_valid;
	logic               out_stall;
	logic signed [31:0] temperature_centi;
	logic [31:0]        pressure_q24_8;
	logic [16:0]        humidity_q22_10;
	logic [1:0]         result_status;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [2:0]         cfg_index;
	logic [63:0]        cfg_data;
	int                 pending;
	int                 fail_count;
	int                 status_seen [3];
	int                 readings_sent;
	int                 results_taken;
	bit                 send_burst;
	bit                 take_burst;

	env_sensor_compensation u_top (.*);

	esc_checker u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#30ms;
		$display("timeout with %0d results outstanding", pending);
		$display("CHECKS FAILED");
		$finish;
	end

	task automatic write_cal(input cfg_idx_t idx, input logic [63:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
	endtask

	task automatic load_calibration(input logic [47:0] tc, input logic [63:0] pa,
			input logic [63:0] pb, input logic [15:0] pc, input logic [63:0] hc);
		write_cal(CFG_TEMP, {16'd0, tc});
		write_cal(CFG_PRESS_A, pa);
		write_cal(CFG_PRESS_B, pb);
		write_cal(CFG_PRESS_C, {{48{pc[15]}}, pc});
		write_cal(CFG_HUM, hc);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_reading(input logic [19:0] ap, input logic [19:0] at,
			input logic [15:0] ah);
		int gap;
		gap = send_burst ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid        <= 1'b1;
		raw_pressure    <= ap;
		raw_temperature <= at;
		raw_humidity    <= ah;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		readings_sent++;
		if (readings_sent % 60 == 0)
			send_burst = !send_burst;
	endtask

	// drain all results and let the back end settle before touching calibration
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (250) @(posedge clk);
	endtask

	task automatic random_reading();
		logic [19:0] ap, at;
		logic [15:0] ah;
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 70) begin
			ap = 20'($urandom_range(200000, 650000));
			at = 20'($urandom_range(380000, 620000));
			ah = 16'($urandom_range(15000, 45000));
		end else begin
			ap = 20'($urandom);
			at = 20'($urandom);
			ah = 16'($urandom);
		end
		sel = $urandom_range(0, 99);
		if (sel < 2)
			ap = SKIP20;
		else if (sel < 4)
			at = SKIP20;
		else if (sel < 6)
			ah = SKIP16;
		send_reading(ap, at, ah);
	endtask

	// receiver: random stalls, one long hold-off to back the block up
	initial begin
		int hold;
		out_stall     <= 1'b1;
		results_taken = 0;
		take_burst    = 0;
		@(posedge arst_n);
		forever begin
			if (results_taken == 300)
				hold = 3000;
			else
				hold = take_burst ? 0 : $urandom_range(0, 7);
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid)
				@(posedge clk);
			results_taken++;
			if (results_taken % 45 == 0)
				take_burst = !take_burst;
		end
	end

	initial begin
		logic [63:0] mask;
		in_valid        <= 1'b0;
		raw_pressure    <= '0;
		raw_temperature <= '0;
		raw_humidity    <= '0;
		cfg_valid       <= 1'b0;
		cfg_index       <= CFG_TEMP;
		cfg_data        <= '0;
		readings_sent   = 0;
		send_burst      = 0;
		arst_n          = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset calibration: zero divisor on every full reading
		send_reading(20'd415148, 20'd519888, 16'd30000);
		send_reading(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
		send_reading(20'd0, 20'd0, 16'd0);
		wait_idle();

		load_calibration(TYP_TEMP, TYP_PRESS_A, TYP_PRESS_B, TYP_PRESS_C, TYP_HUM);
		send_reading(20'd415148, 20'd519888, 16'd30000);
		send_reading(SKIP20, 20'd519888, 16'd30000);
		send_reading(20'd415148, SKIP20, 16'd30000);
		send_reading(20'd415148, 20'd519888, SKIP16);
		send_reading(SKIP20, SKIP20, SKIP16);
		send_reading(20'd0, 20'd0, 16'd0);
		send_reading(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
		send_reading(20'h7FFFF, 20'h80001, 16'h7FFF);
		send_reading(20'd415148, 20'd519888, 16'd0);
		send_reading(20'd415148, 20'd519888, 16'hFFFF);
		send_reading(20'd1048575, 20'd300000, 16'h8001);
		wait_idle();

		// extreme calibration values
		load_calibration('1, '1, '1, 16'h7FFF, '1);
		send_reading(20'd415148, 20'd519888, 16'd30000);
		send_reading(20'hFFFFF, 20'd0, 16'hFFFF);
		wait_idle();
		load_calibration(48'h8000_8000_FFFF, 64'h8000_8000_8000_FFFF, 64'h8000_8000_8000_8000,
			16'h8000, 64'h8080_0800_FF80_00FF);
		send_reading(20'd415148, 20'd519888, 16'd30000);
		send_reading(20'd0, 20'hFFFFF, 16'd0);
		wait_idle();

		for (int ph = 0; ph < N_PHASES; ph++) begin
			if (ph % 3 == 2) begin
				load_calibration(48'({$urandom, $urandom}), {$urandom, $urandom},
					{$urandom, $urandom}, 16'($urandom), {$urandom, $urandom});
			end else begin
				mask = 64'h00FF_007F_00FF_003F;
				load_calibration(TYP_TEMP ^ (48'({$urandom, $urandom}) & mask[47:0]),
					TYP_PRESS_A ^ ({$urandom, $urandom} & mask),
					TYP_PRESS_B ^ ({$urandom, $urandom} & mask),
					TYP_PRESS_C ^ (16'($urandom) & 16'h00FF),
					TYP_HUM ^ ({$urandom, $urandom} & 64'h0F07_0307_1F07_0F1F));
			end
			repeat (PHASE_ITEMS)
				random_reading();
			wait_idle();
		end

		$display("%0d readings over %0d calibration sets with random gaps and stalls",
			readings_sent, N_PHASES + 4);
		$display("results: %0d ok, %0d skipped, %0d zero pressure", status_seen[ST_OK],
			status_seen[ST_SKIP], status_seen[ST_ZERO]);
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// File: sim.f
src/esc_pkg.sv
src/esc_mul.sv
src/esc_div.sv
src/esc_front.sv
src/esc_back.sv
src/env_sensor_compensation.sv
tb/esc_checker.sv
tb/tb_env_sensor_compensation.sv
